@@ hdl/krte_pkg.sv @@
// Shared types, constants and helpers for the keyed record table engine.
`timescale 1ns / 1ps

package krte_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 16;
   localparam int AMT_W    = 16;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 3;
   localparam int POS_W    = 5;
   localparam int USED_W   = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_TAKE   = 2'd1,
      OP_DELETE = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUP      = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_ZERO     = 3'd4,
      ST_SHORT    = 3'd5,
      ST_BADKEY   = 3'd6
   } status_type;

   // How a transaction ends; selects the table update and the response.
   typedef enum logic [3:0] {
      R_BADKEY,
      R_FULL,
      R_NOTFOUND,
      R_DUP,
      R_ZERO,
      R_SHORT,
      R_LOOK,
      R_TAKE,
      R_INSERT,
      R_DELETE
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SEARCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic    load;
      logic    start_scan;
      logic    scan;
      logic    capture;
      logic    shift;
      logic    finish;
      res_type res;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   key_zero;
      logic   full;
      logic   empty;
      logic   hit;
      logic   miss;
      logic   cnt_zero;
      logic   cnt_short;
      logic   shift_done;
   } stat_type;

   function automatic status_type res_to_status(input res_type res);
      status_type st;
      st = ST_OK;
      unique case (res)
         R_BADKEY:   st = ST_BADKEY;
         R_FULL:     st = ST_FULL;
         R_NOTFOUND: st = ST_NOTFOUND;
         R_DUP:      st = ST_DUP;
         R_ZERO:     st = ST_ZERO;
         R_SHORT:    st = ST_SHORT;
         R_LOOK:     st = ST_OK;
         R_TAKE:     st = ST_OK;
         R_INSERT:   st = ST_OK;
         R_DELETE:   st = ST_OK;
         default:    st = ST_OK;
      endcase
      return st;
   endfunction

endpackage

@@ hdl/krte_dp.sv @@
// Datapath: request latch, record table memory, scan/shift pipeline and response registers.
`timescale 1ns / 1ps

module krte_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [krte_pkg::OP_W-1:0]    req_operation,
   input  logic [krte_pkg::KEY_W-1:0]   req_key,
   input  logic [krte_pkg::AMT_W-1:0]   req_amount,
   input  krte_pkg::cmd_type            cmd,
   output krte_pkg::stat_type           stat,
   output logic [krte_pkg::STAT_W-1:0]  rsp_status,
   output logic [krte_pkg::POS_W-1:0]   rsp_position,
   output logic [krte_pkg::AMT_W-1:0]   rsp_count_value,
   output logic [krte_pkg::USED_W-1:0]  rsp_entries_used
);
   import krte_pkg::*;

   logic [KEY_W-1:0] keys_mem   [CAPACITY];
   logic [AMT_W-1:0] counts_mem [CAPACITY];

   op_type           op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [AMT_W-1:0] amount_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0] rd_idx_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [AMT_W-1:0] rd_cnt_ff;
   logic [CNT_W-1:0] slot_ff;
   logic [AMT_W-1:0] slot_cnt_ff;

   logic             issue;
   logic [CNT_W-1:0] rd_idx_next;
   logic [CNT_W-1:0] rd_idx_prev;
   logic             wr_key_en, wr_cnt_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_key;
   logic [AMT_W-1:0] wr_cnt;
   logic [AMT_W-1:0] take_left;

   logic [STAT_W-1:0] status_ff;
   logic [POS_W-1:0]  position_ff;
   logic [AMT_W-1:0]  count_value_ff;
   logic [USED_W-1:0] used_ff;

   assign issue       = (cmd.scan || cmd.shift) && (scan_ptr_ff < count_ff);
   assign rd_idx_next = rd_idx_ff + CNT_W'(1);
   assign rd_idx_prev = rd_idx_ff - CNT_W'(1);
   assign take_left   = slot_cnt_ff - amount_ff;

   assign stat.op         = op_ff;
   assign stat.key_zero   = (key_ff == '0);
   assign stat.full       = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.hit        = rd_valid_ff && (rd_key_ff == key_ff);
   assign stat.miss       = rd_valid_ff && (rd_key_ff != key_ff) && (rd_idx_next == count_ff);
   assign stat.cnt_zero   = (rd_cnt_ff == '0);
   assign stat.cnt_short  = (rd_cnt_ff < amount_ff);
   assign stat.shift_done = (scan_ptr_ff >= count_ff) && !rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_operation);
         key_ff    <= req_key;
         amount_ff <= req_amount;
      end
   end

   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.start_scan) begin
         scan_ptr_in = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.capture) begin
         scan_ptr_in = rd_idx_next;
         rd_valid_in = 1'b0;
      end else if (cmd.scan || cmd.shift) begin
         rd_valid_in = issue;
         if (issue) begin
            scan_ptr_in = scan_ptr_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         rd_valid_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         scan_ptr_ff <= scan_ptr_in;
         rd_valid_ff <= rd_valid_in;
         count_ff    <= count_in;
      end
   end

   // Read side of the table memory.
   always_ff @(posedge clock) begin
      rd_key_ff <= keys_mem[scan_ptr_ff[IDX_W-1:0]];
      rd_cnt_ff <= counts_mem[scan_ptr_ff[IDX_W-1:0]];
      rd_idx_ff <= scan_ptr_ff;
      if (cmd.capture) begin
         slot_ff     <= rd_idx_ff;
         slot_cnt_ff <= rd_cnt_ff;
      end
   end

   always_comb begin
      wr_key_en = 1'b0;
      wr_cnt_en = 1'b0;
      wr_addr   = rd_idx_prev[IDX_W-1:0];
      wr_key    = rd_key_ff;
      wr_cnt    = rd_cnt_ff;
      count_in  = count_ff;
      if (cmd.shift && rd_valid_ff) begin
         wr_key_en = 1'b1;
         wr_cnt_en = 1'b1;
      end else if (cmd.finish) begin
         unique case (cmd.res)
            R_INSERT: begin
               wr_key_en = 1'b1;
               wr_cnt_en = 1'b1;
               wr_addr   = count_ff[IDX_W-1:0];
               wr_key    = key_ff;
               wr_cnt    = amount_ff;
               count_in  = count_ff + CNT_W'(1);
            end
            R_TAKE: begin
               wr_cnt_en = 1'b1;
               wr_addr   = slot_ff[IDX_W-1:0];
               wr_cnt    = take_left;
            end
            R_DELETE: begin
               count_in = count_ff - CNT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Write side of the table memory.
   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         keys_mem[wr_addr] <= wr_key;
      end
      if (wr_cnt_en) begin
         counts_mem[wr_addr] <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= res_to_status(cmd.res);
         used_ff   <= USED_W'(count_in);
         unique case (cmd.res)
            R_BADKEY, R_FULL, R_NOTFOUND: begin
               position_ff    <= '0;
               count_value_ff <= '0;
            end
            R_DUP, R_ZERO, R_SHORT, R_LOOK: begin
               position_ff    <= POS_W'(slot_ff);
               count_value_ff <= slot_cnt_ff;
            end
            R_TAKE: begin
               position_ff    <= POS_W'(slot_ff);
               count_value_ff <= take_left;
            end
            R_INSERT: begin
               position_ff    <= POS_W'(count_ff);
               count_value_ff <= amount_ff;
            end
            R_DELETE: begin
               position_ff    <= POS_W'(slot_ff);
               count_value_ff <= '0;
            end
            default: begin
               position_ff    <= '0;
               count_value_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_position     = position_ff;
   assign rsp_count_value  = count_value_ff;
   assign rsp_entries_used = used_ff;

endmodule

@@ hdl/krte_ctrl.sv @@
// Controller: sequences check, key search, compacting shift and response handoff.
`timescale 1ns / 1ps

module krte_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  krte_pkg::stat_type  stat,
   output krte_pkg::cmd_type   cmd
);
   import krte_pkg::*;

   state_type state_ff, state_in;
   res_type   res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_ff       <= R_BADKEY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      res_in         = res_ff;
      cmd            = '0;
      cmd.res        = res_ff;
      req_stall      = 1'b1;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.key_zero) begin
               res_in   = R_BADKEY;
               state_in = S_FINISH;
            end else if (stat.op == OP_INSERT && stat.full) begin
               res_in   = R_FULL;
               state_in = S_FINISH;
            end else if (stat.empty) begin
               res_in   = (stat.op == OP_INSERT) ? R_INSERT : R_NOTFOUND;
               state_in = S_FINISH;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               cmd.capture = 1'b1;
               state_in    = S_FINISH;
               unique case (stat.op)
                  OP_INSERT: res_in = R_DUP;
                  OP_TAKE: begin
                     if (stat.cnt_zero) begin
                        res_in = R_ZERO;
                     end else if (stat.cnt_short) begin
                        res_in = R_SHORT;
                     end else begin
                        res_in = R_TAKE;
                     end
                  end
                  OP_DELETE: state_in = S_SHIFT;
                  OP_LOOKUP: res_in = R_LOOK;
                  default:   res_in = R_LOOK;
               endcase
            end else if (stat.miss) begin
               res_in   = (stat.op == OP_INSERT) ? R_INSERT : R_NOTFOUND;
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               res_in   = R_DELETE;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/keyed_record_table_engine_unit.sv @@
// Top level of the keyed record table engine: controller, datapath and checks.
`timescale 1ns / 1ps

// Packed table of up to 32 records (nonzero 16-bit key, 16-bit count) supporting
// insert, take, compacting delete and lookup; each transaction returns one
// response. One transaction is in work at a time. When the key is searched,
// the table memory is scanned one slot per cycle through its single read port.
// A delete then shifts the later entries down one per cycle. The response
// sits in an output register, so the next request is taken while a response is
// still stalled; that transaction then waits in its finish state for the register.
module keyed_record_table_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [krte_pkg::OP_W-1:0]    req_operation,
   input  logic [krte_pkg::KEY_W-1:0]   req_key,
   input  logic [krte_pkg::AMT_W-1:0]   req_amount,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [krte_pkg::STAT_W-1:0]  rsp_status,
   output logic [krte_pkg::POS_W-1:0]   rsp_position,
   output logic [krte_pkg::AMT_W-1:0]   rsp_count_value,
   output logic [krte_pkg::USED_W-1:0]  rsp_entries_used
);
   import krte_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   krte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   krte_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_amount       (req_amount),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_count_value  (rsp_count_value),
      .rsp_entries_used (rsp_entries_used)
   );

   a_finish_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a transaction is in work");

   a_used_bounded : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entries_used <= USED_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   a_badkey_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BADKEY) |-> (rsp_position == '0 && rsp_count_value == '0))
      else $error("invalid key response carries a record");

endmodule

@@ tb/sv/keyed_record_table_engine_unit_test.sv @@
// Self-checking testbench for the keyed record table engine: directed and random transactions.
`timescale 1ns / 1ps

module keyed_record_table_engine_unit_test;
   import krte_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int POOL_SIZE    = 40;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_LIMIT  = 50;

   typedef struct {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [AMT_W-1:0]   amount;
      int                 gap;
   } table_req_type;

   typedef struct {
      status_type          status;
      logic [POS_W-1:0]    position;
      logic [AMT_W-1:0]    count_value;
      logic [USED_W-1:0]   entries_used;
   } table_rsp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [AMT_W-1:0]    req_amount = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [POS_W-1:0]    rsp_position;
   logic [AMT_W-1:0]    rsp_count_value;
   logic [USED_W-1:0]   rsp_entries_used;

   table_req_type  pending_reqs[$];
   table_rsp_type  awaited_rsps[$];

   logic [KEY_W-1:0]  tbl_key[CAPACITY];
   logic [AMT_W-1:0]  tbl_cnt[CAPACITY];
   int                tbl_used = 0;

   int           total_items = 0;
   int           accepted_items = 0;
   int           checked_rsps = 0;
   int           mismatches = 0;
   int           req_hold = 0;
   int           rsp_hold = 0;
   int unsigned  cycle_count = 0;

   keyed_record_table_engine_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_count_value  (rsp_count_value),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR t=%0t: %s", $time, msg);
   endtask

   task automatic queue_req(input op_type op, input logic [KEY_W-1:0] key,
                            input logic [AMT_W-1:0] amount, input int gap);
      table_req_type r;
      r.op     = op;
      r.key    = key;
      r.amount = amount;
      r.gap    = gap;
      pending_reqs.push_back(r);
   endtask

   // Applies one transaction to the shadow table and queues its response.
   task automatic apply_table_op(input op_type op, input logic [KEY_W-1:0] key,
                                 input logic [AMT_W-1:0] amount);
      table_rsp_type r;
      int            slot;
      int            i;
      r.status      = ST_OK;
      r.position    = '0;
      r.count_value = '0;
      slot = -1;
      for (i = 0; i < tbl_used; i++)
         if (slot < 0 && tbl_key[i] == key)
            slot = i;
      if (key == '0) begin
         r.status = ST_BADKEY;
      end else if (op == OP_INSERT) begin
         if (tbl_used >= CAPACITY) begin
            r.status = ST_FULL;
         end else if (slot >= 0) begin
            r.status      = ST_DUP;
            r.position    = POS_W'(slot);
            r.count_value = tbl_cnt[slot];
         end else begin
            tbl_key[tbl_used] = key;
            tbl_cnt[tbl_used] = amount;
            r.position        = POS_W'(tbl_used);
            r.count_value     = amount;
            tbl_used++;
         end
      end else if (slot < 0) begin
         r.status = ST_NOTFOUND;
      end else begin
         r.position = POS_W'(slot);
         case (op)
            OP_TAKE: begin
               r.count_value = tbl_cnt[slot];
               if (tbl_cnt[slot] == '0) begin
                  r.status = ST_ZERO;
               end else if (tbl_cnt[slot] < amount) begin
                  r.status = ST_SHORT;
               end else begin
                  tbl_cnt[slot] = tbl_cnt[slot] - amount;
                  r.count_value = tbl_cnt[slot];
               end
            end
            OP_DELETE: begin
               for (i = slot; i + 1 < tbl_used; i++) begin
                  tbl_key[i] = tbl_key[i + 1];
                  tbl_cnt[i] = tbl_cnt[i + 1];
               end
               tbl_used--;
            end
            default: begin
               r.count_value = tbl_cnt[slot];
            end
         endcase
      end
      r.entries_used = USED_W'(tbl_used);
      awaited_rsps.push_back(r);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_table_op(op_type'(req_operation), req_key, req_amount);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            if (req_hold != 0) begin
               req_hold  <= req_hold - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_operation <= pending_reqs[0].op;
               req_key       <= pending_reqs[0].key;
               req_amount    <= pending_reqs[0].amount;
               req_valid     <= 1'b1;
               void'(pending_reqs.pop_front());
               req_hold      <= (pending_reqs.size() > 0) ? pending_reqs[0].gap : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator.
   always @(posedge clock) begin
      int            next_hold;
      table_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         next_hold = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            checked_rsps++;
            if (awaited_rsps.size() == 0) begin
               flag_error("response with no transaction outstanding");
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_status !== want.status)
                  flag_error($sformatf("status got %0d want %0d", rsp_status, want.status));
               if (rsp_position !== want.position)
                  flag_error($sformatf("position got %0d want %0d",
                                       rsp_position, want.position));
               if (rsp_count_value !== want.count_value)
                  flag_error($sformatf("count_value got %0d want %0d",
                                       rsp_count_value, want.count_value));
               if (rsp_entries_used !== want.entries_used)
                  flag_error($sformatf("entries_used got %0d want %0d",
                                       rsp_entries_used, want.entries_used));
            end
            // every fourth stretch of responses runs without stalls
            next_hold = ((checked_rsps / 150) % 4 == 2) ? 0 : $urandom_range(0, 9);
         end
         rsp_hold  <= next_hold;
         rsp_stall <= (next_hold != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] key_pool[POOL_SIZE];
      logic [KEY_W-1:0] k;
      logic [AMT_W-1:0] a;
      op_type           op;
      bit               clash;
      int               i;
      int               j;
      int               sel;
      int               mode;
      int               gap;

      // directed: empty table, zero key, extremes, every status except full
      queue_req(OP_LOOKUP, 16'h0005, 16'h0000, 0);
      queue_req(OP_TAKE,   16'h0005, 16'h0001, 0);
      queue_req(OP_DELETE, 16'h0005, 16'h0000, 0);
      queue_req(OP_INSERT, 16'h0000, 16'h0007, 0);
      queue_req(OP_TAKE,   16'h0000, 16'h0000, 0);
      queue_req(OP_DELETE, 16'h0000, 16'h0000, 0);
      queue_req(OP_LOOKUP, 16'h0000, 16'hFFFF, 0);
      queue_req(OP_INSERT, 16'hFFFF, 16'hFFFF, 0);
      queue_req(OP_INSERT, 16'h0001, 16'h0000, 0);
      queue_req(OP_INSERT, 16'h0002, 16'h0005, 0);
      queue_req(OP_INSERT, 16'h0002, 16'h0009, 0);
      queue_req(OP_TAKE,   16'h0001, 16'h0000, 0);
      queue_req(OP_TAKE,   16'h0002, 16'h0006, 0);
      queue_req(OP_TAKE,   16'h0002, 16'h0000, 0);
      queue_req(OP_TAKE,   16'hFFFF, 16'hFFFF, 0);
      queue_req(OP_TAKE,   16'hFFFF, 16'h0000, 0);
      queue_req(OP_INSERT, 16'h8000, 16'h8000, 0);
      queue_req(OP_DELETE, 16'h0001, 16'h1234, 0);
      queue_req(OP_LOOKUP, 16'h0002, 16'h0000, 0);
      queue_req(OP_DELETE, 16'h8000, 16'h0000, 0);
      queue_req(OP_LOOKUP, 16'h8000, 16'h0000, 0);
      queue_req(OP_TAKE,   16'h0002, 16'hFFFF, 0);

      for (i = 0; i < POOL_SIZE; i++) begin
         do begin
            k = 16'($urandom_range(1, 16'hFFFF));
            clash = 1'b0;
            for (j = 0; j < i; j++)
               if (key_pool[j] == k)
                  clash = 1'b1;
         end while (clash);
         key_pool[i] = k;
      end

      // random: stretches biased to fill, mix or drain the table
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         mode = (i / 100) % 3;
         sel  = $urandom_range(0, 99);
         case (mode)
            0:       op = (sel < 55) ? OP_INSERT : (sel < 75) ? OP_TAKE :
                          (sel < 85) ? OP_DELETE : OP_LOOKUP;
            1:       op = (sel < 30) ? OP_INSERT : (sel < 60) ? OP_TAKE :
                          (sel < 80) ? OP_DELETE : OP_LOOKUP;
            default: op = (sel < 15) ? OP_INSERT : (sel < 40) ? OP_TAKE :
                          (sel < 85) ? OP_DELETE : OP_LOOKUP;
         endcase
         sel = $urandom_range(0, 99);
         if (sel < 3)
            k = '0;
         else if (sel < 8)
            k = 16'($urandom);
         else
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         sel = $urandom_range(0, 99);
         if (op == OP_INSERT)
            a = (sel < 10) ? 16'h0000 : (sel < 50) ? 16'($urandom_range(0, 20))
                                                   : 16'($urandom);
         else
            a = (sel < 50) ? 16'($urandom_range(0, 8)) :
                (sel < 80) ? 16'($urandom_range(0, 40)) : 16'($urandom);
         gap = ((i / 150) % 4 == 1) ? 0 : $urandom_range(0, 9);
         queue_req(op, k, a, gap);
      end
      total_items = pending_reqs.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/krte_pkg.sv
hdl/krte_dp.sv
hdl/krte_ctrl.sv
hdl/keyed_record_table_engine_unit.sv
tb/sv/keyed_record_table_engine_unit_test.sv
